// File: rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

  // default configuration
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // request codes
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_cmd_t;

endpackage

// File: rtl/core/spq_intf.sv
// ---------------------------------------------------------------------------
// spq_intf
// Valid/ready channel interfaces for requests and results.
// ---------------------------------------------------------------------------
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [spq_pkg::FIELD_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic        [spq_pkg::STATUS_W-1:0] status;
  logic signed [spq_pkg::FIELD_W-1:0]  top_value;
  logic        [spq_pkg::COUNT_W-1:0]  entry_count;
  logic                                is_empty;

  modport source (output valid, output status, output top_value,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input top_value,
                  input entry_count, input is_empty, output ready);
endinterface

// File: rtl/core/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the descending chain: holds an entry, compares it with the
// broadcast insert value and shifts with its neighbors.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int INDEX       = 0,
  parameter int CNT_W       = 5,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  spq_pkg::cell_cmd_t            cmd,
  input  logic        [CNT_W-1:0]       count,
  input  logic signed [VALUE_WIDTH-1:0] ins_value,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic                          left_shift,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic signed [VALUE_WIDTH-1:0] entry,
  output logic                          shift
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic signed [VALUE_WIDTH-1:0] entry_r;
  logic signed [VALUE_WIDTH-1:0] entry_nxt;
  logic                          occupied;
  logic                          at_end;

  // flag entries that sit at or below the insert value
  assign occupied = IDX < count;
  assign at_end   = IDX == count;
  assign shift    = occupied && (entry_r <= ins_value);

  // take left or insert value on insert, right on remove, else hold
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      if (left_shift) begin
        entry_nxt = left_value;
      end else if (shift || at_end) begin
        entry_nxt = ins_value;
      end
    end else if (cmd.rem_en) begin
      entry_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/core/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: req_type selects insert or remove of the largest
//   entry, value is the insert operand. out_ch returns one result beat per
//   request: status, largest value after the request (zero when empty),
//   entry count and empty flag.
//   Entries are kept largest first, so cell 0 always holds the top. An insert
//   shifts every entry at or below the new value one cell down the chain in
//   the same cycle; a remove shifts the whole chain up by one cell.
//   The result beat is registered: it appears in the cycle after the request.
//   Throughput: one request per cycle while the receiver keeps up, set by
//   the shift of the cell chain; the result register frees as the receiver
//   takes it. When the receiver stalls, the result beat holds and
//   in_ch.ready drops until it is taken.
//   Reset clears the entry count and the result valid; cell contents are not
//   cleared, only cells below the count are ever read.
//   Insert into a full queue reports STAT_FULL, remove on an empty queue
//   reports STAT_EMPTY; neither changes the stored entries.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH       = spq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic        [CNT_W-1:0]       count_r;
  logic        [CNT_W-1:0]       count_nxt;
  logic                          out_valid_r;
  status_t                       status_r;
  status_t                       status_nxt;
  logic signed [FIELD_W-1:0]     top_r;
  logic signed [FIELD_W-1:0]     top_nxt;
  logic        [COUNT_W-1:0]     count_out_r;
  logic                          empty_r;

  logic                          accept;
  logic                          is_full;
  logic                          is_none;
  cell_cmd_t                     cmd;
  logic signed [VALUE_WIDTH-1:0] ins_value;
  logic signed [VALUE_WIDTH-1:0] top_sel;
  logic signed [VALUE_WIDTH-1:0] cell_entry [DEPTH];
  logic                          cell_shift [DEPTH];

  // accept a request whenever the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = count_r == FULL_CNT;
  assign is_none     = count_r == '0;
  assign ins_value   = VALUE_WIDTH'(in_ch.value);

  // broadcast the chain command
  always_comb begin
    cmd.ins_en = accept && (in_ch.req_type == REQ_INSERT) && !is_full;
    cmd.rem_en = accept && (in_ch.req_type == REQ_REMOVE) && !is_none;
  end

  // build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_shift;
    logic signed [VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = cell_entry[0];
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left_value = cell_entry[i-1];
      assign left_shift = cell_shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_entry[i];
    end else begin : g_next
      assign right_value = cell_entry[i+1];
    end

    spq_cell #(
      .INDEX       (i),
      .CNT_W       (CNT_W),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .ins_value   (ins_value),
      .left_value  (left_value),
      .left_shift  (left_shift),
      .right_value (right_value),
      .entry       (cell_entry[i]),
      .shift       (cell_shift[i])
    );
  end

  // work out status, next count and new top from the current chain head
  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    top_sel    = cell_entry[0];
    if (in_ch.req_type == REQ_INSERT) begin
      if (is_full) begin
        status_nxt = STAT_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        if (is_none || (ins_value >= cell_entry[0])) begin
          top_sel = ins_value;
        end
      end
    end else begin
      if (is_none) begin
        status_nxt = STAT_EMPTY;
        top_sel    = '0;
      end else begin
        count_nxt = count_r - 1'b1;
        top_sel   = (count_r > CNT_W'(1)) ? cell_entry[1] : '0;
      end
    end
    top_nxt = FIELD_W'(top_sel);
  end

  // hold count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // load the result payload on each request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      top_r       <= top_nxt;
      count_out_r <= COUNT_W'(count_nxt);
      empty_r     <= count_nxt == '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.top_value   = top_r;
  assign out_ch.entry_count = count_out_r;
  assign out_ch.is_empty    = empty_r;

endmodule

// File: rtl/core/spq_sva.sv
// ---------------------------------------------------------------------------
// spq_sva
// Port-level checks for the sorted priority queue, bound to the top level.
// ---------------------------------------------------------------------------
module spq_sva (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic        [spq_pkg::STATUS_W-1:0] out_status,
  input logic signed [spq_pkg::FIELD_W-1:0]  out_top_value,
  input logic        [spq_pkg::COUNT_W-1:0]  out_entry_count,
  input logic                                out_is_empty
);
  import spq_pkg::*;

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every request beat yields a result beat in the next cycle
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("request beat without result");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_top_value) && $stable(out_entry_count) && $stable(out_is_empty)))
    else $error("stalled result changed");

  // remove on empty leaves the queue empty with a zero top
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_EMPTY)) |-> (out_is_empty && out_top_value == '0))
    else $error("empty status with non-empty report");

  // an empty queue reports a zero top value and no full status
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_top_value == '0 && out_status != STAT_FULL))
    else $error("empty report with top value or full status");

endmodule

bind sorted_priority_queue spq_sva u_spq_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_top_value   (out_ch.top_value),
  .out_entry_count (out_ch.entry_count),
  .out_is_empty    (out_ch.is_empty)
);

// File: sim/sorted_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A directed request list
// walks reset, extreme values, equal keys, fill to full and remove on empty.
// A long random run follows whose insert/remove mix swings between filling
// and draining. Each result beat is checked against a listed or modelled beat.
// ---------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int Q_DEPTH     = DEPTH_DEF;
  localparam int RAND_ITEMS  = 1000;
  localparam int IDLE_PCT    = 22;
  localparam int MAX_REPORTS = 10;

  // one result beat as seen on out_ch
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [FIELD_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
  } result_t;

  // one row of the directed request list
  typedef struct {
    req_t                      req;
    logic signed [FIELD_W-1:0] value;
    bit                        typed;
    result_t                   want;
  } req_row_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // queue model state
  logic signed [FIELD_W-1:0] model_cells [Q_DEPTH];
  int unsigned               model_count;

  result_t  pending_results [$];
  req_row_t directed_reqs [$];
  int       error_count;
  bit       calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("sorted_priority_queue_tb: done, errors");
    $finish;
  end

  // apply one request to the model and return the result beat it causes
  function automatic result_t queue_predict(req_t req, logic signed [FIELD_W-1:0] value);
    result_t     res;
    int unsigned pos;
    res.status = STAT_OK;
    if (req == REQ_INSERT) begin
      if (model_count >= Q_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        // shift larger entries up, new value lands above its equals
        pos = model_count;
        while (pos > 0 && model_cells[pos-1] > value) begin
          model_cells[pos] = model_cells[pos-1];
          pos--;
        end
        model_cells[pos] = value;
        model_count++;
      end
    end else begin
      if (model_count == 0)
        res.status = STAT_EMPTY;
      else
        model_count--;
    end
    res.top_value   = (model_count > 0) ? model_cells[model_count-1] : '0;
    res.entry_count = model_count[COUNT_W-1:0];
    res.is_empty    = (model_count == 0);
    return res;
  endfunction

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic result_t beat(status_t s, int top, int cnt, bit empty);
    result_t r;
    r.status      = s;
    r.top_value   = top;
    r.entry_count = cnt[COUNT_W-1:0];
    r.is_empty    = empty;
    return r;
  endfunction

  task automatic add_row(req_t req, logic signed [FIELD_W-1:0] value, bit typed = 1'b0,
                         result_t want = '0);
    req_row_t row;
    row.req   = req;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_reqs.push_back(row);
  endtask

  // drive one request beat, hold until accepted, then log its expectation
  task automatic send_req(req_t req, logic signed [FIELD_W-1:0] value, bit typed,
                          result_t want);
    result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value    <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = queue_predict(req, value);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // hold off the sender until every expected beat has come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result sink: random stalls except during the calm stretch
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.top_value   = out_ch.top_value;
      got.entry_count = out_ch.entry_count;
      got.is_empty    = out_ch.is_empty;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected beat status=%0d top=%0d count=%0d empty=%0b",
                             got.status, got.top_value, got.entry_count, got.is_empty));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.top_value !== want.top_value ||
            got.entry_count !== want.entry_count || got.is_empty !== want.is_empty)
          note_error($sformatf(
            "exp status=%0d top=%0d count=%0d empty=%0b, got status=%0d top=%0d count=%0d empty=%0b",
            want.status, want.top_value, want.entry_count, want.is_empty,
            got.status, got.top_value, got.entry_count, got.is_empty));
      end
    end
  end

  // stimulus
  initial begin
    int       ins_pct;
    int       sel;
    req_t     req;
    logic signed [FIELD_W-1:0] value;
    req_row_t row;

    error_count    = 0;
    calm           = 1'b0;
    model_count    = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_INSERT;
    in_ch.value    <= '0;

    // remove on empty, extremes, equal keys, fill to full, drop when full, refill
    add_row(REQ_REMOVE, 0, 1'b1, beat(STAT_EMPTY, 0, 0, 1'b1));
    add_row(REQ_INSERT, 32'h7FFF_FFFF, 1'b1, beat(STAT_OK, 32'h7FFF_FFFF, 1, 1'b0));
    add_row(REQ_INSERT, 32'h8000_0000, 1'b1, beat(STAT_OK, 32'h7FFF_FFFF, 2, 1'b0));
    add_row(REQ_INSERT, 0);
    add_row(REQ_INSERT, 0);
    add_row(REQ_INSERT, -1);
    add_row(REQ_INSERT, 1);
    add_row(REQ_INSERT, 32'h7FFF_FFFF, 1'b1, beat(STAT_OK, 32'h7FFF_FFFF, 7, 1'b0));
    add_row(REQ_REMOVE, 32'hFFFF_FFFF);
    add_row(REQ_INSERT, 32'h8000_0000);
    add_row(REQ_INSERT, 5);
    add_row(REQ_INSERT, -5);
    add_row(REQ_INSERT, 100);
    add_row(REQ_INSERT, -100);
    add_row(REQ_INSERT, 32'h5555_5555);
    add_row(REQ_INSERT, 32'hAAAA_AAAA);
    add_row(REQ_INSERT, 2);
    add_row(REQ_INSERT, -2);
    add_row(REQ_INSERT, 3);
    add_row(REQ_INSERT, 12345, 1'b1, beat(STAT_FULL, 32'h7FFF_FFFF, 16, 1'b0));
    add_row(REQ_REMOVE, 0);
    add_row(REQ_REMOVE, 0);
    add_row(REQ_INSERT, 32'h7FFF_FFFF);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_reqs[i]) begin
      row = directed_reqs[i];
      send_req(row.req, row.value, row.typed, row.want);
    end

    // let everything settle before the random run
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // swing the mix between filling, churning and draining
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: begin
            ins_pct = 85;
          end
          1: begin
            ins_pct = 50;
          end
          default: begin
            ins_pct = 15;
          end
        endcase
      end
      calm = (i >= 400 && i < 600);
      req  = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
      sel  = $urandom_range(9);
      if (sel <= 3)
        value = $urandom;
      else if (sel <= 6)
        value = $signed($urandom_range(15)) - 8;
      else if (sel == 7)
        value = 32'h7FFF_FFFF;
      else if (sel == 8)
        value = 32'h8000_0000;
      else
        value = $urandom_range(1) ? 0 : -1;
      send_req(req, value, 1'b0, '0);
    end

    // wait out the tail, then settle
    drain();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d expected beats never arrived", pending_results.size()));

    if (error_count == 0)
      $display("sorted_priority_queue_tb: done, clean");
    else
      $display("sorted_priority_queue_tb: done, errors");
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_intf.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_sva.sv
sim/sorted_priority_queue_tb.sv
